### rtl/core/rucp_pkg.sv
`timescale 1ns / 1ps

package rucp_pkg;

  // Unlock key length, clamped to the table size
  localparam int KeyLen    = 10;
  localparam int KeyTabLen = 16;
  localparam int WinLen    = (KeyLen < 1) ? 1 : ((KeyLen > KeyTabLen) ? KeyTabLen : KeyLen);

  // Unlock key bytes (ASCII), zero padded
  localparam logic [7:0] UnlockKey [KeyTabLen] = '{
    8'h54, 8'h48, 8'h45, 8'h50, 8'h49, 8'h43, 8'h4f, 8'h53,
    8'h49, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Bus addresses
  localparam logic [4:0] AddrCmd     = 5'h1d;
  localparam logic [4:0] AddrRelockA = 5'h1e;
  localparam logic [4:0] AddrRelockB = 5'h1f;

  // Command codes
  localparam logic [7:0] CmdEcho     = 8'h00;
  localparam logic [7:0] CmdCfgWrite = 8'h01;
  localparam logic [7:0] CmdCfgRead  = 8'h02;
  localparam logic [7:0] CmdLedOn    = 8'h03;
  localparam logic [7:0] CmdLedOff   = 8'h04;
  localparam logic [7:0] CmdVerMajor = 8'hfd;
  localparam logic [7:0] CmdVerMinor = 8'hfe;
  localparam logic [7:0] CmdVerPatch = 8'hff;

  localparam logic [7:0] EchoMask       = 8'h88;
  localparam logic [7:0] PendingReset   = 8'h88;
  localparam logic [3:0] InitCfgReset   = 4'h3;

  // Configuration register indexes
  localparam logic [1:0] RegInitCfg  = 2'd0;
  localparam logic [1:0] RegVerMajor = 2'd1;
  localparam logic [1:0] RegVerMinor = 2'd2;
  localparam logic [1:0] RegVerPatch = 2'd3;

  // One result item
  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       config_written;
    logic [7:0] config_byte;
    logic [3:0] current_config_out;
    logic       led_write;
    logic       led_on;
    logic       unlocked;
  } result_t;

endpackage

### rtl/core/register_unlock_command_port.sv
`timescale 1ns / 1ps

// Channel   | Handshake                  | Payload
// ----------+----------------------------+---------------------------------------
// in        | in_valid_i / in_ready_o    | write_address_i, write_data_i
// out       | out_valid_o / out_ready_i  | reply_*, config_*, current_config_out_o,
//           |                            | led_*, unlocked_o
// cfg       | cfg_we_i (no wait)         | cfg_index_i, cfg_data_i
//
// Each request is decoded in the cycle it is accepted and its result is registered, so one
// request per cycle is sustained while the output buffer has a free entry.
// The key window shift-and-compare and the command decode sit between the state registers
// and the output register.
// A two-entry output buffer (output register plus skid) keeps in_ready_o high while one
// result waits; the input stalls only when both entries are full.
// Reset clears the key window and the flags, sets the pending command to 0x88 and loads the
// default config; no clearing pass is needed.
module register_unlock_command_port (
  input  logic       clk_i,
  input  logic       rst_ni,
  // config write port
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // bus write requests
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [4:0] write_address_i,
  input  logic [7:0] write_data_i,
  // results
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       reply_valid_o,
  output logic [7:0] reply_byte_o,
  output logic       config_written_o,
  output logic [7:0] config_byte_o,
  output logic [3:0] current_config_out_o,
  output logic       led_write_o,
  output logic       led_on_o,
  output logic       unlocked_o
);

  // State
  logic [7:0] win_q [rucp_pkg::WinLen];
  logic [7:0] win_d [rucp_pkg::WinLen];
  logic       ready_q, ready_d;
  logic       await_q, await_d;
  logic [7:0] pend_q, pend_d;
  logic [3:0] act_cfg_q, act_cfg_d;
  logic [7:0] ver_major_q, ver_minor_q, ver_patch_q;

  // Output buffer
  rucp_pkg::result_t res;
  rucp_pkg::result_t out_q, out_d, skid_q, skid_d;
  logic              ov_q, ov_d, sv_q, sv_d;

  logic push, pop, key_match;

  assign in_ready_o = ~sv_q;
  assign push       = in_valid_i & in_ready_o;
  assign pop        = ov_q & out_ready_i;

  // Request decode
  always_comb begin
    win_d     = win_q;
    ready_d   = ready_q;
    await_d   = await_q;
    pend_d    = pend_q;
    act_cfg_d = act_cfg_q;
    res       = '0;
    key_match = 1'b1;

    if (write_address_i == rucp_pkg::AddrCmd) begin
      if (!ready_q) begin
        // shift window and compare against the key
        for (int i = 0; i < rucp_pkg::WinLen - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[rucp_pkg::WinLen-1] = write_data_i;
        for (int i = 0; i < rucp_pkg::WinLen; i++) begin
          if (win_d[i] != rucp_pkg::UnlockKey[i]) key_match = 1'b0;
        end
        if (key_match) ready_d = 1'b1;
      end else if (!await_q) begin
        unique case (write_data_i)
          rucp_pkg::CmdEcho, rucp_pkg::CmdCfgWrite: begin
            pend_d  = write_data_i;
            await_d = 1'b1;
          end
          rucp_pkg::CmdCfgRead: begin
            res.reply_valid = 1'b1;
            res.reply_byte  = {4'h0, act_cfg_q};
          end
          rucp_pkg::CmdLedOn: begin
            res.led_write = 1'b1;
            res.led_on    = 1'b1;
            ready_d       = 1'b0;
          end
          rucp_pkg::CmdLedOff: begin
            res.led_write = 1'b1;
            ready_d       = 1'b0;
          end
          rucp_pkg::CmdVerMajor: begin
            res.reply_valid = 1'b1;
            res.reply_byte  = ver_major_q;
            ready_d         = 1'b0;
          end
          rucp_pkg::CmdVerMinor: begin
            res.reply_valid = 1'b1;
            res.reply_byte  = ver_minor_q;
            ready_d         = 1'b0;
          end
          rucp_pkg::CmdVerPatch: begin
            res.reply_valid = 1'b1;
            res.reply_byte  = ver_patch_q;
            ready_d         = 1'b0;
          end
          default: ready_d = 1'b0;
        endcase
      end else begin
        // value byte for the pending command
        if (pend_q == rucp_pkg::CmdEcho) begin
          res.reply_valid = 1'b1;
          res.reply_byte  = write_data_i ^ rucp_pkg::EchoMask;
        end else if (pend_q == rucp_pkg::CmdCfgWrite) begin
          res.config_written = 1'b1;
          res.config_byte    = write_data_i;
          act_cfg_d          = write_data_i[3:0];
        end
        await_d = 1'b0;
        ready_d = 1'b0;
      end
    end else if (write_address_i == rucp_pkg::AddrRelockA ||
                 write_address_i == rucp_pkg::AddrRelockB) begin
      ready_d = 1'b0;
    end

    res.current_config_out = act_cfg_d;
    res.unlocked           = ready_d;
  end

  // Output register plus skid entry
  always_comb begin
    out_d  = out_q;
    skid_d = skid_q;
    ov_d   = ov_q;
    sv_d   = sv_q;
    if (pop) begin
      if (sv_q) begin
        out_d = skid_q;
        sv_d  = 1'b0;
      end else begin
        ov_d = 1'b0;
      end
    end
    if (push) begin
      if (!ov_d) begin
        out_d = res;
        ov_d  = 1'b1;
      end else begin
        skid_d = res;
        sv_d   = 1'b1;
      end
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rucp_pkg::WinLen; i++) begin
        win_q[i] <= 8'h00;
      end
      ready_q     <= 1'b0;
      await_q     <= 1'b0;
      pend_q      <= rucp_pkg::PendingReset;
      act_cfg_q   <= rucp_pkg::InitCfgReset;
      ver_major_q <= 8'h00;
      ver_minor_q <= 8'h00;
      ver_patch_q <= 8'h00;
      ov_q        <= 1'b0;
      sv_q        <= 1'b0;
    end else begin
      ov_q <= ov_d;
      sv_q <= sv_d;
      if (push) begin
        win_q     <= win_d;
        ready_q   <= ready_d;
        await_q   <= await_d;
        pend_q    <= pend_d;
        act_cfg_q <= act_cfg_d;
      end
      // the user must write config only while idle; the block itself does not enforce it
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          rucp_pkg::RegInitCfg:  act_cfg_q   <= cfg_data_i[3:0];
          rucp_pkg::RegVerMajor: ver_major_q <= cfg_data_i;
          rucp_pkg::RegVerMinor: ver_minor_q <= cfg_data_i;
          rucp_pkg::RegVerPatch: ver_patch_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o          = ov_q;
  assign reply_valid_o        = out_q.reply_valid;
  assign reply_byte_o         = out_q.reply_byte;
  assign config_written_o     = out_q.config_written;
  assign config_byte_o        = out_q.config_byte;
  assign current_config_out_o = out_q.current_config_out;
  assign led_write_o          = out_q.led_write;
  assign led_on_o             = out_q.led_on;
  assign unlocked_o           = out_q.unlocked;

endmodule

### rtl/core/rucp_checker.sv
`timescale 1ns / 1ps

module rucp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       reply_valid_o,
  input logic [7:0] reply_byte_o,
  input logic       config_written_o,
  input logic [7:0] config_byte_o,
  input logic [3:0] current_config_out_o,
  input logic       led_write_o,
  input logic       led_on_o,
  input logic       unlocked_o
);

  // idle reply field reads as zero
  a_reply_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !reply_valid_o) |-> (reply_byte_o == 8'h00))
    else $error("reply byte set without reply");

  // a config write shows its low nibble as the active config
  a_cfg_applied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && config_written_o) |-> (current_config_out_o == config_byte_o[3:0]))
    else $error("config byte not applied");

  // config write and LED commands always relock, and never coincide
  a_relock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (config_written_o || led_write_o)) |->
      (!unlocked_o && !(config_written_o && led_write_o) && !reply_valid_o))
    else $error("command did not relock");

  // LED level only meaningful with a LED write
  a_led_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !led_write_o) |-> !led_on_o)
    else $error("LED level without LED write");

  // input stalls only while a result is held at the output
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

bind register_unlock_command_port rucp_checker u_rucp_checker (.*);
